[rtl/afc_pkg.sv]
// afc_pkg: shared types and constants of the audio frame cutter
// request action codes, result status codes, register indexes and reset values
// no dependencies
`default_nettype none

package afc_pkg;

    // field widths fixed by the request and result formats
    localparam int unsigned ACTION_W  = 2;
    localparam int unsigned STATUS_W  = 2;
    localparam int unsigned INDEX_W   = 11;
    localparam int unsigned FLEN_W    = 12;
    localparam int unsigned HOP_W     = 13;
    localparam int unsigned MINV_W    = 12;
    localparam int unsigned START_W   = 14;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DAT_W = 13;

    // frame start saturates here
    localparam logic [START_W-1:0] START_MAX = '1;

    // register reset values
    localparam logic [FLEN_W-1:0] FLEN_RST = 12'd1024;
    localparam logic [HOP_W-1:0]  HOP_RST  = 13'd512;
    localparam logic              CENT_RST = 1'b1;
    localparam logic              RUN_RST  = 1'b0;
    localparam logic [MINV_W-1:0] MINV_RST = 12'd0;

    // request actions
    typedef enum logic [ACTION_W-1:0] {
        ACT_APPEND  = 2'd0,
        ACT_FETCH   = 2'd1,
        ACT_RESTART = 2'd2
    } t_action;

    // result status
    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_NO_FRAME = 2'd1,
        ST_CFG_ERR  = 2'd2
    } t_status;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_LENGTH = 3'd0,
        CFG_HOP_LENGTH   = 3'd1,
        CFG_CENTERED     = 3'd2,
        CFG_RUN_TO_END   = 3'd3,
        CFG_MIN_VALID    = 3'd4
    } t_cfg_idx;

    // result waiting on the sample memory read
    typedef struct packed {
        logic [INDEX_W-1:0] index;
        logic               done;
        t_status            status;
        logic               use_ram;
    } t_pending;

endpackage

`default_nettype wire

[rtl/afc_req_if.sv]
// afc_req_if: request channel of the audio frame cutter (valid, ready, action, sample)
// depends on afc_pkg
`default_nettype none

interface afc_req_if
    import afc_pkg::*;
#(
    parameter int unsigned SAMPLE_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic [ACTION_W-1:0]           action;
    logic signed [SAMPLE_BITS-1:0] sample_in;

    modport source (output valid, output action, output sample_in, input ready);
    modport sink   (input valid, input action, input sample_in, output ready);
endinterface

`default_nettype wire

[rtl/afc_res_if.sv]
// afc_res_if: result channel of the audio frame cutter (valid, ready, frame element)
// depends on afc_pkg
`default_nettype none

interface afc_res_if
    import afc_pkg::*;
#(
    parameter int unsigned SAMPLE_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_out;
    logic [INDEX_W-1:0]            element_index;
    logic                          frame_done;
    logic [STATUS_W-1:0]           status;

    modport source (output valid, output sample_out, output element_index,
                    output frame_done, output status, input ready);
    modport sink   (input valid, input sample_out, input element_index,
                    input frame_done, input status, output ready);
endinterface

`default_nettype wire

[rtl/afc_ram.sv]
// afc_ram: generic single-port synchronous RAM, registered read, read data held
// between reads; no dependencies
`default_nettype none

module afc_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_en,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // one access a cycle: write, or read into the output register
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                o_rdata <= r_mem[i_addr];
            end
        end
    end

endmodule

`default_nettype wire

[rtl/audio_frame_cutter.sv]
// audio_frame_cutter: sample buffer with overlapping zero-padded frame readout
// depends on afc_pkg, afc_req_if, afc_res_if, afc_ram
//
// Usage: requests arrive on i_req. Action append stores one sample unless the
// buffer is full, fetch returns one frame element on o_res, restart empties the
// buffer and rewinds the frame start. Appends and restarts give no result.
// Registers are written on i_cfg_we (index, data); the user must write them only
// while the block is idle, and the block itself does not enforce this.
// Throughput: one request a cycle while the receiver takes results; the single
// port of the sample memory serves either one append write or one fetch read
// per cycle, and an append read back by the next fetch sees the new sample.
// A fetch result waits in a pending stage with the memory read data held;
// while both it and the output register are full and the receiver is not
// ready, i_req.ready is low, so at most two results are in flight and a
// stalled receiver stops the requests.
// Reset: buffer empty, no frame open, registers at their reset values; the
// sample memory is not cleared, unwritten entries are never read.
`default_nettype none

module audio_frame_cutter
    import afc_pkg::*;
#(
    parameter int unsigned BUFFER_DEPTH = 4096,
    parameter int unsigned MAX_FRAME    = 2048,
    parameter int unsigned SAMPLE_BITS  = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    afc_req_if.sink                   i_req,
    afc_res_if.source                 o_res,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_DAT_W-1:0] i_cfg_data
);

    localparam int unsigned AW = $clog2(BUFFER_DEPTH);
    localparam int unsigned CW = $clog2(BUFFER_DEPTH + 1);
    localparam int unsigned PW = ((CW > 15) ? CW : 15) + 2;
    localparam logic [13:0] MAX_FRAME_V = 14'(MAX_FRAME);
    localparam logic signed [PW-1:0] DEPTH_S = PW'(BUFFER_DEPTH);

    // configuration registers
    logic [FLEN_W-1:0] r_flen;
    logic [HOP_W-1:0]  r_hop;
    logic              r_cent;
    logic              r_run;
    logic [MINV_W-1:0] r_minv;

    // frame state
    logic [CW-1:0]      r_cnt, n_cnt;
    logic [START_W-1:0] r_fs, n_fs;
    logic               r_ended, n_ended;
    logic [INDEX_W-1:0] r_ep, n_ep;
    logic               r_open, n_open;

    // pending and output stages
    logic                   r_p_valid, n_p_valid;
    t_pending               r_p, n_p;
    logic                   r_o_valid;
    logic [SAMPLE_BITS-1:0] r_o_sample;
    logic [INDEX_W-1:0]     r_o_index;
    logic                   r_o_done;
    t_status                r_o_status;

    logic                   move;
    logic                   req_acc;
    t_action                act;
    logic                   ram_en, ram_we, ram_re;
    logic [AW-1:0]          ram_addr;
    logic [SAMPLE_BITS-1:0] ram_rdata;

    logic [FLEN_W-1:0]     half_up;
    logic signed [PW-1:0]  s_pos, cnt_s, fl_s, d_s, valid_s, pos_s, minv_s, half_s;
    logic                  cfg_bad, short, can_open, ended_set, last, rd_ok;
    logic [START_W:0]      fs_sum;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flen <= FLEN_RST;
            r_hop  <= HOP_RST;
            r_cent <= CENT_RST;
            r_run  <= RUN_RST;
            r_minv <= MINV_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_FRAME_LENGTH: r_flen <= i_cfg_data[FLEN_W-1:0];
                CFG_HOP_LENGTH:   r_hop  <= i_cfg_data[HOP_W-1:0];
                CFG_CENTERED:     r_cent <= i_cfg_data[0];
                CFG_RUN_TO_END:   r_run  <= i_cfg_data[0];
                CFG_MIN_VALID:    r_minv <= i_cfg_data[MINV_W-1:0];
                default: ;
            endcase
        end
    end

    // handshake
    assign move        = r_p_valid && (!r_o_valid || o_res.ready);
    assign i_req.ready = !r_p_valid || move;
    assign req_acc     = i_req.valid && i_req.ready;
    assign act         = t_action'(i_req.action);

    // frame geometry from the current registers
    always_comb begin
        half_up = FLEN_W'(({1'b0, r_flen} + 13'd1) >> 1);
        half_s  = $signed({{(PW-FLEN_W){1'b0}}, (r_flen >> 1)});
        cnt_s   = $signed({{(PW-CW){1'b0}}, r_cnt});
        fl_s    = $signed({{(PW-FLEN_W){1'b0}}, r_flen});
        minv_s  = $signed({{(PW-MINV_W){1'b0}}, r_minv});
        s_pos   = $signed({{(PW-START_W){1'b0}}, r_fs})
                - (r_cent ? $signed({{(PW-FLEN_W){1'b0}}, half_up}) : '0);
        d_s     = cnt_s - s_pos;
        short   = d_s < fl_s;
        valid_s = short ? d_s : fl_s;
        pos_s   = s_pos + $signed({{(PW-INDEX_W){1'b0}}, r_ep});
        rd_ok   = (pos_s >= 0) && (pos_s < cnt_s) && (pos_s < DEPTH_S);

        cfg_bad = (r_flen == '0) || ({2'b00, r_flen} > MAX_FRAME_V)
               || (r_cent && ({r_minv, 1'b0} > {1'b0, r_flen}));
        can_open = !r_ended && (r_cnt != '0) && (s_pos < cnt_s) && !(valid_s < minv_s);
        // last-frame rules
        ended_set = (!r_cent && !r_run && (d_s <= fl_s))
                 || (r_cent && short && (d_s <= half_s));
        last   = ({1'b0, r_ep} + 12'd1) >= r_flen;
        fs_sum = {1'b0, r_fs} + (START_W+1)'(r_hop);
    end

    // request handling and next state
    always_comb begin
        n_cnt     = r_cnt;
        n_fs      = r_fs;
        n_ended   = r_ended;
        n_ep      = r_ep;
        n_open    = r_open;
        n_p_valid = r_p_valid && !move;
        n_p       = r_p;
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        ram_addr  = pos_s[AW-1:0];
        if (req_acc) begin
            unique case (act)
                ACT_APPEND: begin
                    if (r_cnt < CW'(BUFFER_DEPTH)) begin
                        ram_we   = 1'b1;
                        ram_addr = r_cnt[AW-1:0];
                        n_cnt    = r_cnt + CW'(1);
                    end
                end
                ACT_RESTART: begin
                    n_cnt   = '0;
                    n_fs    = '0;
                    n_ended = 1'b0;
                    n_ep    = '0;
                    n_open  = 1'b0;
                end
                ACT_FETCH: begin
                    n_p_valid = 1'b1;
                    n_p       = '{index: '0, done: 1'b0, status: ST_OK, use_ram: 1'b0};
                    priority if (cfg_bad) begin
                        n_p.status = ST_CFG_ERR;
                    end else if (!r_open && !can_open) begin
                        n_p.status = ST_NO_FRAME;
                    end else begin
                        ram_re    = rd_ok;
                        n_p.use_ram = rd_ok;
                        n_p.index = r_ep;
                        n_p.done  = last;
                        if (!r_open && ended_set) begin
                            n_ended = 1'b1;
                        end
                        if (last) begin
                            n_fs   = (fs_sum > {1'b0, START_MAX}) ? START_MAX
                                                                  : fs_sum[START_W-1:0];
                            n_open = 1'b0;
                            n_ep   = '0;
                        end else begin
                            n_open = 1'b1;
                            n_ep   = r_ep + INDEX_W'(1);
                        end
                    end
                end
                default: ;
            endcase
        end
        ram_en = ram_we || ram_re;
    end

    // state and pending registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt     <= '0;
            r_fs      <= '0;
            r_ended   <= 1'b0;
            r_ep      <= '0;
            r_open    <= 1'b0;
            r_p_valid <= 1'b0;
        end else begin
            r_cnt     <= n_cnt;
            r_fs      <= n_fs;
            r_ended   <= n_ended;
            r_ep      <= n_ep;
            r_open    <= n_open;
            r_p_valid <= n_p_valid;
        end
        r_p <= n_p;
    end

    // output register, loaded from the pending stage and the memory read data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (move) begin
            r_o_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_o_valid <= 1'b0;
        end
        if (move) begin
            r_o_sample <= r_p.use_ram ? ram_rdata : '0;
            r_o_index  <= r_p.index;
            r_o_done   <= r_p.done;
            r_o_status <= r_p.status;
        end
    end

    assign o_res.valid         = r_o_valid;
    assign o_res.sample_out    = r_o_sample;
    assign o_res.element_index = r_o_index;
    assign o_res.frame_done    = r_o_done;
    assign o_res.status        = r_o_status;

    // sample memory
    afc_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (BUFFER_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_en    (ram_en),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (i_req.sample_in),
        .o_rdata (ram_rdata)
    );

    // single memory port never asked for a write and a read together
    a_port_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(ram_we && ram_re))
        else $error("sample memory write and read in one cycle");

    // a new request never overwrites a pending result
    a_pend_safe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (req_acc && r_p_valid) |-> move)
        else $error("pending result overwritten");

    // every fetch leaves a pending result
    a_fetch_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (req_acc && (act == ACT_FETCH)) |=> r_p_valid)
        else $error("fetch without result");

    // stored count within the buffer
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(BUFFER_DEPTH))
        else $error("stored count beyond buffer");

    // refused fetches carry an empty element
    a_err_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && (r_o_status != ST_OK))
            |-> ((r_o_sample == '0) && (r_o_index == '0) && !r_o_done))
        else $error("refused fetch with element data");

endmodule

`default_nettype wire
